FILE: design/qkd_pkg.sv
// ----------------------------------------------------------------------------
// qkd_pkg
// Shared types, constants and the quadrature transition table of the knob
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qkd_pkg;

  // Field and counter widths
  localparam int PosWidthDef = 16;        // default position width
  localparam int RegW        = 16;        // width of limit and encoder debounce regs
  localparam int CntW        = 20;        // microsecond counters, button debounce
  localparam int CfgDataW    = 20;        // widest config register
  localparam int CfgIdxW     = 2;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // Register reset values
  localparam logic signed [RegW-1:0] PosMinRst = 16'sd0;
  localparam logic signed [RegW-1:0] PosMaxRst = 16'sd100;
  localparam logic [RegW-1:0]        EncDbRst  = 16'd1000;
  localparam logic [CntW-1:0]        BtnDbRst  = 20'd200000;

  // Item kinds
  typedef enum logic [1:0] {
    KindSample = 2'd0,
    KindPoll   = 2'd1,
    KindZero   = 2'd2,
    KindSet    = 2'd3
  } kind_e;

  // Poll results
  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvCw    = 2'd1,
    EvCcw   = 2'd2,
    EvPress = 2'd3
  } event_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegPosMin = 2'd0,
    RegPosMax = 2'd1,
    RegEncDb  = 2'd2,
    RegBtnDb  = 2'd3
  } cfg_idx_e;

  // Decoded step of one phase transition
  typedef enum logic [1:0] {
    StepNone = 2'd0,
    StepCcw  = 2'd1,
    StepCw   = 2'd2
  } step_e;

  // Transition table, indexed by {previous phase, new phase}
  localparam logic [1:0] StepLut [16] = '{
    2'd0, 2'd1, 2'd2, 2'd0,
    2'd2, 2'd0, 2'd0, 2'd1,
    2'd1, 2'd0, 2'd0, 2'd2,
    2'd0, 2'd2, 2'd1, 2'd0
  };

  // Configuration register set
  typedef struct packed {
    logic signed [RegW-1:0] pos_min;
    logic signed [RegW-1:0] pos_max;
    logic [RegW-1:0]        enc_db;
    logic [CntW-1:0]        btn_db;
  } cfg_t;

  // One input item
  typedef struct packed {
    kind_e                  kind;
    logic                   pin_a;
    logic                   pin_b;
    logic                   button;
    logic signed [RegW-1:0] new_position;
  } item_t;

  function automatic step_e step_lookup(input logic [3:0] idx);
    logic [1:0] code;
    code = StepLut[idx];
    unique case (code)
      2'd1:    return StepCcw;
      2'd2:    return StepCw;
      default: return StepNone;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: design/qkd_cfg_regs.sv
// ----------------------------------------------------------------------------
// qkd_cfg_regs
// Configuration register file: clamp limits and the two debounce times.
// ----------------------------------------------------------------------------
`default_nettype none

module qkd_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [qkd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [qkd_pkg::CfgDataW-1:0] cfg_data_i,
  output qkd_pkg::cfg_t                     cfg_o
);
  import qkd_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  // Register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        RegPosMin: cfg_d.pos_min = cfg_data_i[RegW-1:0];
        RegPosMax: cfg_d.pos_max = cfg_data_i[RegW-1:0];
        RegEncDb:  cfg_d.enc_db  = cfg_data_i[RegW-1:0];
        RegBtnDb:  cfg_d.btn_db  = cfg_data_i[CntW-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_min <= PosMinRst;
      cfg_q.pos_max <= PosMaxRst;
      cfg_q.enc_db  <= EncDbRst;
      cfg_q.btn_db  <= BtnDbRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: design/qkd_core.sv
// ----------------------------------------------------------------------------
// qkd_core
// Decoder state and the single-pass update for one item: debounce, x4
// transition decode, detent counting, clamping and event flags.
// ----------------------------------------------------------------------------
`default_nettype none

module qkd_core #(
  parameter int POSITION_WIDTH = qkd_pkg::PosWidthDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_en_i,
  input  wire qkd_pkg::item_t             item_i,
  input  wire qkd_pkg::cfg_t              cfg_i,
  output qkd_pkg::event_e                 event_o,
  output logic signed [POSITION_WIDTH-1:0] position_o
);
  import qkd_pkg::*;

  // Clamp arithmetic width: room for either limit set plus one step
  localparam int CW = ((POSITION_WIDTH > RegW) ? POSITION_WIDTH : RegW) + 2;
  localparam logic signed [CW-1:0] PosHi =
    {{(CW-POSITION_WIDTH+1){1'b0}}, {(POSITION_WIDTH-1){1'b1}}};
  localparam logic signed [CW-1:0] PosLo = ~PosHi;

  logic [1:0]                      prev_phase_q, prev_phase_d;
  logic [2:0]                      last_pins_q, last_pins_d;
  logic signed [2:0]               tick_q, tick_d;
  logic signed [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic [CntW-1:0]                 since_enc_q, since_enc_d;
  logic [CntW-1:0]                 since_btn_q, since_btn_d;
  logic                            moved_q, moved_d;
  logic                            dir_q, dir_d;
  logic                            pressed_q, pressed_d;

  logic [CntW-1:0]   enc_inc, btn_inc;
  logic [1:0]        phase;
  logic              enc_ok, btn_ok;
  step_e             step;
  logic signed [3:0] tick_sum;
  logic              detent;
  logic signed [CW-1:0] pos_ext, pos_step, lim_min, lim_max, set_ext;
  logic signed [CW-1:0] step_clamped, set_clamped;
  event_e            ev;

  function automatic logic signed [CW-1:0] clamp(input logic signed [CW-1:0] p,
                                                 input logic signed [CW-1:0] mn,
                                                 input logic signed [CW-1:0] mx);
    logic signed [CW-1:0] r;
    r = p;
    if (r < mn) r = mn;
    if (r > mx) r = mx;
    if (r < PosLo) r = PosLo;
    if (r > PosHi) r = PosHi;
    return r;
  endfunction

  // Saturating microsecond counters, advanced before the compare
  assign enc_inc = (since_enc_q == CntMax) ? CntMax : since_enc_q + 1'b1;
  assign btn_inc = (since_btn_q == CntMax) ? CntMax : since_btn_q + 1'b1;

  // Phase change and debounce qualification
  assign phase  = {item_i.pin_a, item_i.pin_b};
  assign enc_ok = (phase != last_pins_q[2:1]) &&
                  (enc_inc >= {{(CntW-RegW){1'b0}}, cfg_i.enc_db});
  assign btn_ok = last_pins_q[0] && !item_i.button && (btn_inc >= cfg_i.btn_db);
  assign step   = step_lookup({prev_phase_q, phase});

  // Tick accumulate and detent detect
  assign tick_sum = {tick_q[2], tick_q} + ((step == StepCw) ? 4'sd1 : -4'sd1);
  assign detent   = (tick_sum == 4'sd4) || (tick_sum == -4'sd4);

  // Operands for the clamp
  assign pos_ext  = {{(CW-POSITION_WIDTH){pos_q[POSITION_WIDTH-1]}}, pos_q};
  assign pos_step = pos_ext + ((step == StepCw) ? CW'(1) : {CW{1'b1}});
  assign lim_min  = {{(CW-RegW){cfg_i.pos_min[RegW-1]}}, cfg_i.pos_min};
  assign lim_max  = {{(CW-RegW){cfg_i.pos_max[RegW-1]}}, cfg_i.pos_max};
  assign set_ext  = {{(CW-RegW){item_i.new_position[RegW-1]}}, item_i.new_position};

  // Clamped candidates for a detent and for a loaded position
  assign step_clamped = clamp(pos_step, lim_min, lim_max);
  assign set_clamped  = clamp(set_ext, lim_min, lim_max);

  // Next state for one item
  always_comb begin
    prev_phase_d = prev_phase_q;
    last_pins_d  = last_pins_q;
    tick_d       = tick_q;
    pos_d        = pos_q;
    since_enc_d  = since_enc_q;
    since_btn_d  = since_btn_q;
    moved_d      = moved_q;
    dir_d        = dir_q;
    pressed_d    = pressed_q;
    ev           = EvNone;
    unique case (item_i.kind)
      KindSample: begin
        since_enc_d = enc_inc;
        since_btn_d = btn_inc;
        last_pins_d = {item_i.pin_a, item_i.pin_b, item_i.button};
        if (enc_ok) begin
          since_enc_d  = '0;
          prev_phase_d = phase;
          if (step != StepNone) begin
            dir_d  = (step == StepCw);
            tick_d = tick_sum[2:0];
            if (detent) begin
              tick_d  = '0;
              pos_d   = step_clamped[POSITION_WIDTH-1:0];
              moved_d = 1'b1;
            end
          end
        end
        if (btn_ok) begin
          since_btn_d = '0;
          pressed_d   = 1'b1;
        end
      end
      KindPoll: begin
        // Rotation has priority over a press
        if (moved_q) begin
          moved_d = 1'b0;
          ev      = dir_q ? EvCw : EvCcw;
        end else if (pressed_q) begin
          pressed_d = 1'b0;
          ev        = EvPress;
        end
      end
      KindZero: begin
        pos_d  = '0;
        tick_d = '0;
      end
      KindSet: begin
        pos_d  = set_clamped[POSITION_WIDTH-1:0];
        tick_d = '0;
      end
      default: ev = EvNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_phase_q <= 2'b11;
      last_pins_q  <= 3'b111;
      tick_q       <= '0;
      pos_q        <= '0;
      since_enc_q  <= '0;
      since_btn_q  <= '0;
      moved_q      <= 1'b0;
      dir_q        <= 1'b0;
      pressed_q    <= 1'b0;
    end else if (step_en_i) begin
      prev_phase_q <= prev_phase_d;
      last_pins_q  <= last_pins_d;
      tick_q       <= tick_d;
      pos_q        <= pos_d;
      since_enc_q  <= since_enc_d;
      since_btn_q  <= since_btn_d;
      moved_q      <= moved_d;
      dir_q        <= dir_d;
      pressed_q    <= pressed_d;
    end
  end

  assign event_o    = ev;
  assign position_o = pos_d;

endmodule

`default_nettype wire

FILE: design/quadrature_knob_decoder.sv
// ----------------------------------------------------------------------------
// quadrature_knob_decoder
// x4 quadrature knob decoder with detent clamping, debounce and poll events.
// ----------------------------------------------------------------------------
// Every accepted item gives exactly one result. An item is registered on
// entry, then decoded against the knob state in one pass and written to the
// output register, which presents the result. A new item is taken every
// cycle; the only thing that slows the block is a stalled output
// (out_ready_i low), which holds the result and then the entry register.
// Configuration writes are always ready and take effect on the next cycle;
// write them only while no item is in flight. There is no clearing pass
// after reset.
`default_nettype none

module quadrature_knob_decoder #(
  parameter int POSITION_WIDTH = qkd_pkg::PosWidthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Item input
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   kind_i,
  input  wire logic                         pin_a_i,
  input  wire logic                         pin_b_i,
  input  wire logic                         button_i,
  input  wire logic signed [qkd_pkg::RegW-1:0] new_position_i,
  // Result output
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [1:0]                        event_res_o,
  output logic signed [POSITION_WIDTH-1:0]  position_o,
  // Configuration writes
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [qkd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [qkd_pkg::CfgDataW-1:0] cfg_data_i
);
  import qkd_pkg::*;

  cfg_t   cfg;
  item_t  item_q;
  logic   item_valid_q;
  logic   out_valid_q;
  logic   advance;
  event_e ev_d, ev_q;
  logic signed [POSITION_WIDTH-1:0] pos_d, pos_q;

  // Handshake: entry register moves into the output register when it is free
  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  // Configuration registers
  qkd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Entry register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  // Entry register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.kind         <= kind_e'(kind_i);
      item_q.pin_a        <= pin_a_i;
      item_q.pin_b        <= pin_b_i;
      item_q.button       <= button_i;
      item_q.new_position <= new_position_i;
    end
  end

  // Decoder state and update
  qkd_core #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_en_i  (advance),
    .item_i     (item_q),
    .cfg_i      (cfg),
    .event_o    (ev_d),
    .position_o (pos_d)
  );

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= item_valid_q;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      ev_q  <= ev_d;
      pos_q <= pos_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = ev_q;
  assign position_o  = pos_q;

endmodule

`default_nettype wire

FILE: design/qkd_checker.sv
// ----------------------------------------------------------------------------
// qkd_checker
// Port-level checks of the knob decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qkd_checker #(
  parameter int POSITION_WIDTH = qkd_pkg::PosWidthDef
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [1:0]                   event_res_o,
  input wire logic signed [POSITION_WIDTH-1:0] position_o,
  input wire logic                         cfg_valid_i,
  input wire logic                         cfg_ready_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_res_o) &&
                                    $stable(position_o))
    else $error("result changed while stalled");

  // With the output register empty the input side never stalls
  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // An item taken while the output register is empty shows up after passing the entry and output registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> ##1 out_valid_o)
    else $error("result missing two cycles after accept");

  // Configuration writes are never held off
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind quadrature_knob_decoder qkd_checker #(
  .POSITION_WIDTH (POSITION_WIDTH)
) u_qkd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .event_res_o (event_res_o),
  .position_o  (position_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire

FILE: tb/sv/qkd_tb_pkg.sv
// ----------------------------------------------------------------------------
// qkd_tb_pkg
// Scoreboard of the knob decoder testbench: predicts the result of every
// input transaction and checks the results that the decoder returns.
// ----------------------------------------------------------------------------
package qkd_tb_pkg;

  import qkd_pkg::*;

  // x4 decode: {previous phase, new phase} -> step
  localparam step_e PhaseStep [16] = '{
    StepNone, StepCcw,  StepCw,   StepNone,
    StepCw,   StepNone, StepNone, StepCcw,
    StepCcw,  StepNone, StepNone, StepCw,
    StepNone, StepCw,   StepCcw,  StepNone
  };

  typedef struct packed {
    event_e                 ev;
    logic signed [RegW-1:0] pos;
  } knob_result_t;

  class knob_scoreboard;

    // Register copies
    int              pos_min;
    int              pos_max;
    logic [RegW-1:0] enc_db;
    logic [CntW-1:0] btn_db;

    // Knob state
    logic [1:0]      prev_phase;
    logic [2:0]      last_pins;
    int              ticks;
    int              position;
    logic [CntW-1:0] since_enc;
    logic [CntW-1:0] since_btn;
    bit              moved;
    bit              turned_cw;
    bit              pressed;

    knob_result_t    expected_q[$];
    int              failures;
    int              results_seen;

    function new();
      pos_min    = PosMinRst;
      pos_max    = PosMaxRst;
      enc_db     = EncDbRst;
      btn_db     = BtnDbRst;
      prev_phase = 2'b11;
      last_pins  = 3'b111;
      ticks      = 0;
      position   = 0;
      since_enc  = '0;
      since_btn  = '0;
      moved      = 1'b0;
      turned_cw  = 1'b0;
      pressed    = 1'b0;
      failures   = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegPosMin: pos_min = $signed(data[RegW-1:0]);
        RegPosMax: pos_max = $signed(data[RegW-1:0]);
        RegEncDb:  enc_db  = data[RegW-1:0];
        default:   btn_db  = data;
      endcase
    endfunction

    // Lower limit first, then upper, so inverted limits end at pos_max
    function int clamp_position(int p);
      if (p < pos_min) p = pos_min;
      if (p > pos_max) p = pos_max;
      return p;
    endfunction

    // Advance the state by one accepted input transaction
    function void note_input(item_t it);
      logic [1:0]   phase;
      step_e        stp;
      event_e       ev;
      int           steps;
      knob_result_t res;
      ev = EvNone;
      case (it.kind)
        KindSample: begin
          phase = {it.pin_a, it.pin_b};
          if (since_enc != CntMax) since_enc++;
          if (since_btn != CntMax) since_btn++;
          // encoder: only a debounced change of the A/B pair counts
          if (phase != last_pins[2:1] && since_enc >= enc_db) begin
            stp        = PhaseStep[{prev_phase, phase}];
            since_enc  = '0;
            prev_phase = phase;
            if (stp != StepNone) begin
              if (stp == StepCcw) begin
                ticks--;
                turned_cw = 1'b0;
              end else begin
                ticks++;
                turned_cw = 1'b1;
              end
              if (ticks >= 4 || ticks <= -4) begin
                steps    = ticks / 4;
                ticks    = ticks - steps * 4;
                position = clamp_position(position + steps);
                moved    = 1'b1;
              end
            end
          end
          // button: debounced falling edge
          if (last_pins[0] && !it.button && since_btn >= btn_db) begin
            since_btn = '0;
            pressed   = 1'b1;
          end
          last_pins = {it.pin_a, it.pin_b, it.button};
        end
        KindPoll: begin
          if (moved) begin
            moved = 1'b0;
            ev    = turned_cw ? EvCw : EvCcw;
          end else if (pressed) begin
            pressed = 1'b0;
            ev      = EvPress;
          end
        end
        KindZero: begin
          position = 0;
          ticks    = 0;
        end
        default: begin
          position = clamp_position($signed(it.new_position));
          ticks    = 0;
        end
      endcase
      res.ev  = ev;
      res.pos = position[RegW-1:0];
      expected_q.push_back(res);
    endfunction

    // Compare one result transaction with the oldest prediction
    function void check_result(logic [1:0] ev, logic signed [RegW-1:0] pos);
      knob_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result %0d: no transaction pending, event %0d position %0d",
                   results_seen, ev, pos);
        return;
      end
      want = expected_q.pop_front();
      if (ev !== want.ev) begin
        failures++;
        if (failures <= 10)
          $display("result %0d: event expected %0d got %0d", results_seen, want.ev, ev);
      end
      if (pos !== want.pos) begin
        failures++;
        if (failures <= 10)
          $display("result %0d: position expected %0d got %0d",
                   results_seen, want.pos, pos);
      end
    endfunction

  endclass

endpackage

FILE: tb/sv/quadrature_knob_decoder_tb.sv
// ----------------------------------------------------------------------------
// quadrature_knob_decoder_tb
// Drives pin samples, polls and position loads into the knob decoder under
// several register settings and random handshake stalls; every result is
// checked against a scoreboard that tracks the knob state.
// ----------------------------------------------------------------------------
module quadrature_knob_decoder_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import qkd_pkg::*;
  import qkd_tb_pkg::*;

  localparam int DrainSettle = 4;
  localparam int EndSettle   = 8;
  localparam int QuietLimit  = 2000;  // cycles without any transaction

  logic                     clk_i;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid    = 1'b0;
  logic                     in_ready;
  logic [1:0]               kind        = '0;
  logic                     pin_a       = 1'b1;
  logic                     pin_b       = 1'b1;
  logic                     button      = 1'b1;
  logic signed [RegW-1:0]   new_position = '0;
  logic                     out_valid;
  logic                     out_ready   = 1'b0;
  logic [1:0]               event_res;
  logic signed [RegW-1:0]   position;
  logic                     cfg_valid   = 1'b0;
  logic                     cfg_ready;
  logic [CfgIdxW-1:0]       cfg_index   = '0;
  logic [CfgDataW-1:0]      cfg_data    = '0;

  knob_scoreboard board;
  int         sent;
  int         snd_idle_pct;
  int         rcv_idle_pct;
  int         quiet_cycles;
  int         gen_enc;
  logic [1:0] knob_phase = 2'b11;
  logic       btn_level  = 1'b1;
  bit         spin_cw;

  quadrature_knob_decoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (kind),
    .pin_a_i        (pin_a),
    .pin_b_i        (pin_b),
    .button_i       (button),
    .new_position_i (new_position),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .event_res_o    (event_res),
    .position_o     (position),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: check, then pick next cycle's ready
  always @(posedge clk_i) begin
    if (out_valid && out_ready) board.check_result(event_res, position);
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input transaction, with a random gap before it
  task automatic send_item(input kind_e k, input logic a, input logic b,
                           input logic btn, input logic [RegW-1:0] np);
    item_t it;
    snd_idle_pct = (sent < 630) ? 24 : (sent < 1260) ? 68 : 0;
    rcv_idle_pct = (sent < 630) ? 68 : (sent < 1260) ? 24 : 0;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    it.kind         = k;
    it.pin_a        = a;
    it.pin_b        = b;
    it.button       = btn;
    it.new_position = np;
    in_valid     <= 1'b1;
    kind         <= k;
    pin_a        <= a;
    pin_b        <= b;
    button       <= btn;
    new_position <= np;
    do @(posedge clk_i); while (!in_ready);
    board.note_input(it);
    sent++;
  endtask

  task automatic sample(input logic a, input logic b, input logic btn);
    send_item(KindSample, a, b, btn, 16'($urandom));
  endtask

  // Hold off the sender until every predicted result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainSettle) @(posedge clk_i);
  endtask

  // Write all four registers back to back while the decoder is idle
  task automatic write_config(input int pmin, input int pmax, input int enc,
                              input int btn);
    cfg_idx_e            idx;
    logic [CfgDataW-1:0] data;
    drain();
    for (int i = 0; i < 4; i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        RegPosMin: data = {4'($urandom), 16'(pmin)};
        RegPosMax: data = {4'($urandom), 16'(pmax)};
        RegEncDb:  data = {4'($urandom), 16'(enc)};
        default:   data = 20'(btn);
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= data;
      do @(posedge clk_i); while (!cfg_ready);
      board.write_reg(idx, data);
    end
    cfg_valid <= 1'b0;
    gen_enc = enc;
  endtask

  // Mostly clean knob turns and button presses, with polls and some noise
  task automatic run_random(input int budget);
    int               stop;
    int               roll;
    int               hold;
    logic [1:0]       nxt;
    logic [RegW-1:0]  np;
    stop = sent + budget;
    while (sent < stop) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        if ($urandom_range(9) == 0) spin_cw = !spin_cw;
        if ($urandom_range(19) == 0) begin
          nxt = ~knob_phase;                  // skipped phase
        end else if (spin_cw) begin
          case (knob_phase)
            2'b11:   nxt = 2'b01;
            2'b01:   nxt = 2'b00;
            2'b00:   nxt = 2'b10;
            default: nxt = 2'b11;
          endcase
        end else begin
          case (knob_phase)
            2'b11:   nxt = 2'b10;
            2'b10:   nxt = 2'b00;
            2'b00:   nxt = 2'b01;
            default: nxt = 2'b11;
          endcase
        end
        // a short hold now and then lands inside the debounce window
        hold = ($urandom_range(9) == 0) ? $urandom_range(1, 3)
                                        : gen_enc + $urandom_range(0, 2);
        if (hold < 1) hold = 1;
        if (hold > 8) hold = 8;
        knob_phase = nxt;
        repeat (hold) sample(knob_phase[1], knob_phase[0], btn_level);
      end else if (roll < 65) begin
        btn_level = !btn_level;
        repeat ($urandom_range(1, 3)) sample(knob_phase[1], knob_phase[0], btn_level);
      end else if (roll < 85) begin
        send_item(KindPoll, 1'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
      end else if (roll < 90) begin
        case ($urandom_range(3))
          0:       np = 16'h7FFF;
          1:       np = 16'h8000;
          2:       np = 16'($urandom_range(0, 40) - 20);
          default: np = 16'($urandom);
        endcase
        send_item(KindSet, 1'($urandom), 1'($urandom), 1'($urandom), np);
      end else if (roll < 92) begin
        send_item(KindZero, 1'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
      end else if (roll < 97) begin
        knob_phase = 2'($urandom);
        btn_level  = 1'($urandom);
        sample(knob_phase[1], knob_phase[0], btn_level);
      end else if (roll < 99) begin
        send_item(kind_e'($urandom_range(3)), 1'($urandom), 1'($urandom),
                  1'($urandom), 16'($urandom));
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    board        = new();
    sent         = 0;
    gen_enc      = EncDbRst;
    spin_cw      = 1'b1;
    snd_idle_pct = 24;
    rcv_idle_pct = 68;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: changes and presses right after reset are debounced away
    send_item(KindPoll, 1'b1, 1'b1, 1'b1, 16'h0000);
    sample(1'b0, 1'b1, 1'b0);
    sample(1'b1, 1'b1, 1'b1);
    send_item(KindSet, 1'b0, 1'b0, 1'b0, 16'h7FFF);
    send_item(KindSet, 1'b1, 1'b1, 1'b1, 16'h8000);
    send_item(KindSet, 1'b0, 1'b1, 1'b0, 16'd50);
    send_item(KindZero, 1'b1, 1'b0, 1'b1, 16'hFFFF);
    send_item(KindPoll, 1'b0, 1'b0, 1'b0, 16'h5555);

    // No debounce: one clockwise detent, a press, polls in priority order
    write_config(-5, 5, 0, 0);
    sample(1'b0, 1'b1, 1'b1);
    sample(1'b0, 1'b0, 1'b1);
    sample(1'b1, 1'b0, 1'b1);
    sample(1'b1, 1'b1, 1'b1);
    sample(1'b1, 1'b1, 1'b0);
    send_item(KindPoll, 1'b0, 1'b0, 1'b0, 16'h0000);
    send_item(KindPoll, 1'b1, 1'b1, 1'b1, 16'hFFFF);
    send_item(KindPoll, 1'b0, 1'b0, 1'b0, 16'h0000);
    // two counterclockwise detents, then skipped phases
    repeat (2) begin
      sample(1'b1, 1'b0, 1'b1);
      sample(1'b0, 1'b0, 1'b1);
      sample(1'b0, 1'b1, 1'b1);
      sample(1'b1, 1'b1, 1'b1);
    end
    sample(1'b0, 1'b0, 1'b1);
    sample(1'b1, 1'b1, 1'b1);
    send_item(KindPoll, 1'b0, 1'b0, 1'b0, 16'h0000);
    send_item(KindSet, 1'b0, 1'b0, 1'b0, 16'd9);

    // Random phases under several register settings
    write_config(-10, 10, 1, 3);
    run_random(300);
    write_config(0 - int'($urandom_range(0, 20)), $urandom_range(0, 20),
                 $urandom_range(0, 3), $urandom_range(0, 30));
    run_random(300);
    write_config(-32768, 32767, 0, 0);
    run_random(250);
    write_config(5, -5, 2, 10);
    run_random(200);
    write_config(32767, -32768, 65535, 1048575);
    run_random(40);
    write_config(-32768, -32760, 0, 1);
    run_random(200);
    write_config($urandom, $urandom, $urandom_range(0, 3), $urandom_range(0, 50));
    run_random(300);
    write_config(0, 100, 3, 100);
    run_random(260);

    drain();
    repeat (EndSettle) @(posedge clk_i);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
